// ----- src/kmss_pkg.sv -----
// Package for the keyed multi-stack store: parameter defaults, result status codes
// and the command and status structs between the controller and the datapath.
// Depends on nothing; the top level, controller and datapath refer to it by scoped names.
package kmss_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_TYPES_DEF    = 16;
    localparam int STACK_DEPTH_DEF  = 64;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Fixed widths of the item and result fields.
    localparam int CODE_W    = 16;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int PENDING_W = 5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd3;

    // Operation codes of the func field.
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the incoming item
        logic match;       // compare the code against every claimed slot
        logic exec;        // decide, update the tables and access the stack memory
        logic finish_pop;  // stack memory read data is valid: deliver the pop result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_read;    // the item being executed is a successful pop
    } stat_t;

endpackage

// ----- src/keyed_multi_stack_store.sv -----
// Top level of the keyed multi-stack store: joins the controller and the datapath.
// Depends on kmss_pkg, kmss_ctrl, kmss_dp and, through the datapath, kmss_ram.
//
// Usage. An item (func, type_code, payload) is taken at a rising edge where start
// is high and busy is low. A push (func 0) finds the type code in the type table,
// claims the next free slot when the code is new, and pushes the payload onto
// that slot's stack. A pop (func 1) removes and returns the top word of the code's
// stack; it never claims a slot. Each item yields exactly one result, shown on
// status, popped_payload and pending_stacks for a single cycle while done is high.
// The receiver cannot hold a result off, so it must take it in that cycle.
// Busy stays high from the take until the result is shown, so a new item is
// not taken before the last one is through. The steps are the match of the
// code against every claimed slot, the update of tables and stack memory, and
// for a successful pop the registered read of the single-port stack memory.
// While done is high, busy is already low and the next item may be taken.
// Reset clears the claimed bits, stack heights and counters at once; the stack
// memory and stored codes need no clearing, as they are read only once written.
module keyed_multi_stack_store #(
    parameter int NUM_TYPES    = kmss_pkg::NUM_TYPES_DEF,
    parameter int STACK_DEPTH  = kmss_pkg::STACK_DEPTH_DEF,
    parameter int PAYLOAD_BITS = kmss_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            func,
    input  logic [kmss_pkg::CODE_W-1:0]     type_code,
    input  logic [kmss_pkg::WORD_W-1:0]     payload,
    output logic                            done,
    output logic [kmss_pkg::STATUS_W-1:0]   status,
    output logic [kmss_pkg::WORD_W-1:0]     popped_payload,
    output logic [kmss_pkg::PENDING_W-1:0]  pending_stacks
);

    kmss_pkg::cmd_t  cmd;
    kmss_pkg::stat_t stat;

    // The controller steps each item through capture, match and execute, and
    // adds the read-back step for a successful pop.
    kmss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // The datapath holds all state and drives the result ports from registers.
    kmss_dp #(
        .NUM_TYPES    (NUM_TYPES),
        .STACK_DEPTH  (STACK_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .func           (func),
        .type_code      (type_code),
        .payload        (payload),
        .done           (done),
        .status         (status),
        .popped_payload (popped_payload),
        .pending_stacks (pending_stacks)
    );

endmodule

// ----- src/kmss_ram.sv -----
// Generic single-port RAM with a registered read, used for the stack words.
// Depends on nothing.
module kmss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/kmss_ctrl.sv -----
// Controller of the keyed multi-stack store: sequences capture, match, execute
// and the pop read-back. Depends on kmss_pkg for the command and status structs.
module kmss_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output kmss_pkg::cmd_t  cmd,
    input  kmss_pkg::stat_t stat
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_POP   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.capture    = 1'b0;
        cmd.match      = 1'b0;
        cmd.exec       = 1'b0;
        cmd.finish_pop = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                // A successful pop goes on to S_POP for the registered stack memory read.
                state_next = stat.pop_read ? S_POP : S_IDLE;
            end
            S_POP:
            begin
                cmd.finish_pop = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- src/kmss_dp.sv -----
// Datapath of the keyed multi-stack store: type table, stack heights, counters,
// stack memory and result registers. Depends on kmss_pkg and kmss_ram.
module kmss_dp #(
    parameter int NUM_TYPES    = kmss_pkg::NUM_TYPES_DEF,
    parameter int STACK_DEPTH  = kmss_pkg::STACK_DEPTH_DEF,
    parameter int PAYLOAD_BITS = kmss_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kmss_pkg::cmd_t                  cmd,
    output kmss_pkg::stat_t                 stat,
    input  logic                            func,
    input  logic [kmss_pkg::CODE_W-1:0]     type_code,
    input  logic [kmss_pkg::WORD_W-1:0]     payload,
    output logic                            done,
    output logic [kmss_pkg::STATUS_W-1:0]   status,
    output logic [kmss_pkg::WORD_W-1:0]     popped_payload,
    output logic [kmss_pkg::PENDING_W-1:0]  pending_stacks
);

    localparam int IDX_W   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int CNT_W   = $clog2(NUM_TYPES + 1);
    localparam int HT_W    = $clog2(STACK_DEPTH + 1);
    localparam int MEM_D   = NUM_TYPES * STACK_DEPTH;
    localparam int ADDR_W  = $clog2(MEM_D);
    localparam int ADDR_XW = (MEM_D > 1) ? ADDR_W : 1;

    // Captured item.
    logic                        func_reg;
    logic [kmss_pkg::CODE_W-1:0] code_reg;
    logic [PAYLOAD_BITS-1:0]     word_reg;

    // Type table and stack state.
    logic [kmss_pkg::CODE_W-1:0] slot_code_reg [NUM_TYPES];
    logic [NUM_TYPES-1:0]        slot_used_reg;
    logic [HT_W-1:0]             height_reg [NUM_TYPES];
    logic [CNT_W-1:0]            claimed_reg;
    logic [CNT_W-1:0]            nonempty_reg;
    logic [NUM_TYPES-1:0]        hit_vec_reg;

    // Result registers.
    logic                          done_reg;
    logic [kmss_pkg::STATUS_W-1:0] status_reg;
    logic [kmss_pkg::WORD_W-1:0]   popped_reg;
    logic [CNT_W-1:0]              pending_reg;

    // Execute-stage decisions.
    logic                          hit;
    logic [IDX_W-1:0]              hit_idx;
    logic [IDX_W-1:0]              slot;
    logic [HT_W-1:0]               h_sel;
    logic [kmss_pkg::STATUS_W-1:0] st_exec;
    logic                          do_claim;
    logic                          do_push;
    logic                          do_pop;
    logic [CNT_W-1:0]              nonempty_next;
    logic [HT_W-1:0]               entry;
    logic [ADDR_XW-1:0]            mem_addr;
    logic [PAYLOAD_BITS-1:0]       mem_rdata;

    // Claimed codes are unique, so at most one hit bit is set and the slot
    // number is the OR of the indices of the set bits.
    always_comb
    begin
        hit     = |hit_vec_reg;
        hit_idx = '0;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            if (hit_vec_reg[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        slot     = hit ? hit_idx : claimed_reg[IDX_W-1:0];
        h_sel    = height_reg[slot];
        st_exec  = kmss_pkg::ST_OK;
        do_claim = 1'b0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        if (func_reg == kmss_pkg::FUNC_PUSH)
        begin
            if (!hit)
            begin
                if (claimed_reg >= CNT_W'(NUM_TYPES))
                begin
                    st_exec = kmss_pkg::ST_TABLE_FULL;
                end
                else
                begin
                    do_claim = 1'b1;
                    do_push  = 1'b1;
                end
            end
            else if (h_sel >= HT_W'(STACK_DEPTH))
            begin
                st_exec = kmss_pkg::ST_STACK_FULL;
            end
            else
            begin
                do_push = 1'b1;
            end
        end
        else
        begin
            if (!hit || (h_sel == '0))
            begin
                st_exec = kmss_pkg::ST_NONE;
            end
            else
            begin
                do_pop = 1'b1;
            end
        end

        nonempty_next = nonempty_reg;
        if (do_push && (h_sel == '0))
        begin
            nonempty_next = nonempty_reg + CNT_W'(1);
        end
        else if (do_pop && (h_sel == HT_W'(1)))
        begin
            nonempty_next = nonempty_reg - CNT_W'(1);
        end

        entry    = do_pop ? (h_sel - HT_W'(1)) : h_sel;
        mem_addr = ADDR_XW'(32'(slot) * 32'(STACK_DEPTH) + 32'(entry));
    end

    assign stat.pop_read = cmd.exec && do_pop;

    // Item capture, match vector, stored codes and popped word; these registers need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            code_reg <= type_code;
            word_reg <= PAYLOAD_BITS'(payload);
        end
        if (cmd.match)
        begin
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                hit_vec_reg[i] <= slot_used_reg[i] && (slot_code_reg[i] == code_reg);
            end
        end
        if (cmd.exec && do_claim)
        begin
            slot_code_reg[slot] <= code_reg;
        end
        if (cmd.exec)
        begin
            popped_reg <= '0;
        end
        else if (cmd.finish_pop)
        begin
            popped_reg <= kmss_pkg::WORD_W'(mem_rdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg <= '0;
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                height_reg[i] <= '0;
            end
            claimed_reg  <= '0;
            nonempty_reg <= '0;
            done_reg     <= 1'b0;
            status_reg   <= kmss_pkg::ST_OK;
            pending_reg  <= '0;
        end
        else
        begin
            done_reg <= (cmd.exec && !do_pop) || cmd.finish_pop;
            if (cmd.exec)
            begin
                status_reg   <= st_exec;
                pending_reg  <= nonempty_next;
                nonempty_reg <= nonempty_next;
                if (do_claim)
                begin
                    slot_used_reg[slot] <= 1'b1;
                    claimed_reg         <= claimed_reg + CNT_W'(1);
                end
                if (do_push)
                begin
                    height_reg[slot] <= h_sel + HT_W'(1);
                end
                else if (do_pop)
                begin
                    height_reg[slot] <= h_sel - HT_W'(1);
                end
            end
        end
    end

    kmss_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (MEM_D)
    ) u_stack_ram (
        .clk   (clk),
        .en    (cmd.exec && (do_push || do_pop)),
        .we    (do_push),
        .addr  (mem_addr[ADDR_W-1:0]),
        .wdata (word_reg),
        .rdata (mem_rdata)
    );

    assign done           = done_reg;
    assign status         = status_reg;
    assign popped_payload = popped_reg;
    assign pending_stacks = kmss_pkg::PENDING_W'(pending_reg);

endmodule
